@@ sv/spheroid_mesh_vertex_generator_macros.svh @@
// Assertion macros for the spheroid mesh vertex generator.
`ifndef SPHEROID_MESH_VERTEX_GENERATOR_MACROS_SVH
`define SPHEROID_MESH_VERTEX_GENERATOR_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SMVG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SMVG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/smvg_pkg.sv @@
// Shared types, constants and functions of the spheroid mesh vertex generator.
package smvg_pkg;

  localparam int MAX_DIVISIONS = 1024;
  localparam int CNT_W         = 11;
  localparam int CORDIC_STAGES = 16;
  localparam int ADIV_STAGES   = 32;
  localparam int ISQ_STAGES    = 32;
  localparam int NDIV_STAGES   = 15;
  localparam int ROT_W         = 34;

  localparam logic signed [ROT_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_RADIUS_X    = 3'd0,
    REG_RADIUS_Y    = 3'd1,
    REG_RADIUS_Z    = 3'd2,
    REG_SLICE_COUNT = 3'd3,
    REG_STACK_COUNT = 3'd4
  } cfg_reg_t;

  // angle division: one quotient bit per cell for each index
  typedef struct packed {
    logic              int_st;
    logic [CNT_W-1:0]  rem_st;
    logic [CNT_W-1:0]  rem_sl;
    logic [31:0]       q_st;
    logic [31:0]       q_sl;
  } adiv_t;

  typedef struct packed {
    logic                    neg;
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] z;
  } rot_t;

  typedef struct packed {
    rot_t phi;
    rot_t theta;
  } cordic_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } isq_t;

  typedef struct packed {
    logic [30:0]        len;
    logic [2:0][30:0]   rem;
    logic [2:0][14:0]   dq;
  } ndiv_t;

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic signed [16:0] z;
  } pos_t;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    if (c == '0) return CNT_W'(1);
    if (c > CNT_W'(MAX_DIVISIONS)) return CNT_W'(MAX_DIVISIONS);
    return c;
  endfunction

endpackage

@@ sv/smvg_adiv_cell.sv @@
// One restoring-division cell: one fraction bit of stack and slice angle.
module smvg_adiv_cell
  import smvg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [CNT_W-1:0] n_st,
  input  logic [CNT_W-1:0] n_sl,
  input  logic             in_valid,
  input  adiv_t            in_d,
  output logic             out_valid,
  output adiv_t            out_d
);

  logic              valid_r;
  adiv_t             d_r;
  adiv_t             d_nxt;
  logic [CNT_W:0]    t_st;
  logic [CNT_W:0]    t_sl;
  logic              b_st;
  logic              b_sl;

  always_comb begin
    t_st  = {in_d.rem_st, 1'b0};
    t_sl  = {in_d.rem_sl, 1'b0};
    b_st  = t_st >= {1'b0, n_st};
    b_sl  = t_sl >= {1'b0, n_sl};
    d_nxt = in_d;
    d_nxt.rem_st = b_st ? CNT_W'(t_st - {1'b0, n_st}) : t_st[CNT_W-1:0];
    d_nxt.rem_sl = b_sl ? CNT_W'(t_sl - {1'b0, n_sl}) : t_sl[CNT_W-1:0];
    d_nxt.q_st   = {in_d.q_st[30:0], b_st};
    d_nxt.q_sl   = {in_d.q_sl[30:0], b_sl};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;

endmodule

@@ sv/smvg_cordic_cell.sv @@
// One CORDIC rotation cell acting on the polar and the azimuth angle.
module smvg_cordic_cell
  import smvg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [4:0]  k,
  input  logic        in_valid,
  input  cordic_t     in_d,
  output logic        out_valid,
  output cordic_t     out_d
);

  logic    valid_r;
  cordic_t d_r;
  cordic_t d_nxt;

  function automatic rot_t rotate(input rot_t a, input logic [4:0] s);
    rot_t                    o;
    logic signed [ROT_W-1:0] dx;
    logic signed [ROT_W-1:0] dy;
    logic signed [ROT_W-1:0] at;
    o  = a;
    dx = a.y >>> s;
    dy = a.x >>> s;
    at = $signed({2'b00, ATAN_TURNS[s]});
    if (!a.z[ROT_W-1]) begin
      o.x = a.x - dx;
      o.y = a.y + dy;
      o.z = a.z - at;
    end else begin
      o.x = a.x + dx;
      o.y = a.y - dy;
      o.z = a.z + at;
    end
    return o;
  endfunction

  always_comb begin
    d_nxt.phi   = rotate(in_d.phi, k);
    d_nxt.theta = rotate(in_d.theta, k);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;

endmodule

@@ sv/smvg_isqrt_cell.sv @@
// One digit cell of the integer square root of the squared length.
module smvg_isqrt_cell
  import smvg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [5:0]  b,
  input  logic        in_valid,
  input  isq_t        in_d,
  output logic        out_valid,
  output isq_t        out_d
);

  logic        valid_r;
  isq_t        d_r;
  isq_t        d_nxt;
  logic [63:0] bit_v;
  logic [63:0] t;

  always_comb begin
    bit_v = 64'd1 << b;
    t     = in_d.r + bit_v;
    if (in_d.v >= t) begin
      d_nxt.v = in_d.v - t;
      d_nxt.r = (in_d.r >> 1) + bit_v;
    end else begin
      d_nxt.v = in_d.v;
      d_nxt.r = in_d.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;

endmodule

@@ sv/smvg_ndiv_cell.sv @@
// One restoring-division cell: one quotient bit of each normal component.
module smvg_ndiv_cell
  import smvg_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_valid,
  input  ndiv_t  in_d,
  output logic   out_valid,
  output ndiv_t  out_d
);

  logic  valid_r;
  ndiv_t d_r;
  ndiv_t d_nxt;

  always_comb begin
    logic [31:0] t;
    logic        qb;
    d_nxt = in_d;
    for (int i = 0; i < 3; i++) begin
      t  = {in_d.rem[i], in_d.dq[i][14]};
      qb = t >= {1'b0, in_d.len};
      d_nxt.rem[i] = qb ? 31'(t - {1'b0, in_d.len}) : t[30:0];
      d_nxt.dq[i]  = {in_d.dq[i][13:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = d_r;

endmodule

@@ sv/spheroid_mesh_vertex_generator.sv @@
// Spheroid mesh vertex generator: top level with the cell chains and output register.
// Takes one (stack, slice) index pair per transaction and returns one vertex position
// and unit normal per transaction, one vertex per clock cycle while not stalled. The
// chain holds 32 angle-division cells, 16 CORDIC cells, 5 rounding/multiply/sum
// stages, 32 square-root cells, 15 normal-division cells and the output register.
// The whole chain advances together; it stalls only when the output holds a result
// that is not taken and the last cell has another one ready. Configuration writes
// take effect at once and must land only while no vertex is in flight.
module spheroid_mesh_vertex_generator
  import smvg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  // cfg
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // stack_index[10:0], slice_index[21:11], zero pad
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // pos_x[16:0], pos_y[33:17], pos_z[50:34],
                                   // norm_x[66:51], norm_y[82:67], norm_z[98:83], pad
);

  // configuration registers
  logic [15:0]      rx_r, ry_r, rz_r;
  logic [CNT_W-1:0] slices_r, stacks_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r     <= 16'd256;
      ry_r     <= 16'd256;
      rz_r     <= 16'd256;
      slices_r <= CNT_W'(16);
      stacks_r <= CNT_W'(16);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIUS_X:    rx_r     <= cfg_data;
        REG_RADIUS_Y:    ry_r     <= cfg_data;
        REG_RADIUS_Z:    rz_r     <= cfg_data;
        REG_SLICE_COUNT: slices_r <= cfg_data[CNT_W-1:0];
        REG_STACK_COUNT: stacks_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  logic [98:0] out_data_r;
  logic last_v;

  assign en        = !(out_valid_r && !out_tready && last_v);
  assign in_tready = en;

  // angle division chain
  logic [CNT_W-1:0] n_st, n_sl, st_sat, sl_sat, st_in, sl_in;
  adiv_t            adiv_d [ADIV_STAGES+1];
  logic             adiv_v [ADIV_STAGES+1];

  assign n_st  = eff_count(stacks_r);
  assign n_sl  = eff_count(slices_r);
  assign st_in = in_tdata[10:0];
  assign sl_in = in_tdata[21:11];

  always_comb begin
    st_sat = (st_in > n_st) ? n_st : st_in;
    sl_sat = (sl_in > n_sl) ? n_sl : sl_in;
    adiv_d[0].int_st = st_sat == n_st;
    adiv_d[0].rem_st = (st_sat == n_st) ? '0 : st_sat;
    adiv_d[0].rem_sl = (sl_sat == n_sl) ? '0 : sl_sat;
    adiv_d[0].q_st   = '0;
    adiv_d[0].q_sl   = '0;
  end
  assign adiv_v[0] = in_tvalid;

  for (genvar i = 0; i < ADIV_STAGES; i++) begin : g_adiv
    smvg_adiv_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .n_st(n_st), .n_sl(n_sl),
      .in_valid(adiv_v[i]), .in_d(adiv_d[i]),
      .out_valid(adiv_v[i+1]), .out_d(adiv_d[i+1])
    );
  end

  // fold to [-1/4, 1/4) turn, then CORDIC chain
  function automatic rot_t fold(input logic [31:0] a);
    rot_t        o;
    logic [31:0] s;
    logic [31:0] f;
    s     = a + 32'h4000_0000;
    o.neg = s[31];
    f     = s[31] ? (a ^ 32'h8000_0000) : a;
    o.x   = CORDIC_GAIN_Q30;
    o.y   = '0;
    o.z   = ROT_W'($signed(f));
    return o;
  endfunction

  cordic_t cor_d [CORDIC_STAGES+1];
  logic    cor_v [CORDIC_STAGES+1];

  assign cor_d[0].phi   = fold({adiv_d[ADIV_STAGES].int_st, adiv_d[ADIV_STAGES].q_st[31:1]});
  assign cor_d[0].theta = fold(adiv_d[ADIV_STAGES].q_sl);
  assign cor_v[0]       = adiv_v[ADIV_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    smvg_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .k(5'(i)),
      .in_valid(cor_v[i]), .in_d(cor_d[i]),
      .out_valid(cor_v[i+1]), .out_d(cor_d[i+1])
    );
  end

  function automatic logic signed [17:0] rnd_q16(input logic signed [ROT_W-1:0] v,
                                                 input logic neg);
    logic signed [ROT_W-1:0] n;
    logic signed [ROT_W:0]   t;
    logic signed [20:0]      s;
    n = neg ? -v : v;
    t = {n[ROT_W-1], n} + (ROT_W+1)'(8192);
    s = t[ROT_W:14];
    if (s > 21'sd65536) return 18'sd65536;
    if (s < -21'sd65536) return -18'sd65536;
    return s[17:0];
  endfunction

  function automatic logic signed [16:0] clamp17(input logic signed [21:0] v);
    if (v > 22'sd65535) return 17'sd65535;
    if (v < -22'sd65535) return -17'sd65535;
    return v[16:0];
  endfunction

  // rounding stage
  logic signed [17:0] sp_r, cp_r, stt_r, ct_r;
  logic               rnd_v_r;
  // first multiply stage
  logic signed [34:0] ax_r, az_r;
  logic signed [16:0] py1_r;
  logic signed [17:0] ct1_r, stt1_r;
  logic               m1_v_r;
  // second multiply stage
  pos_t               p2_r;
  logic               m2_v_r;
  // squares and sum
  logic [2:0][33:0]   sq_r;
  pos_t               p3_r;
  logic               sq_v_r;
  logic [33:0]        s_r;
  pos_t               p4_r;
  logic               sum_v_r;

  logic signed [34:0] py_prod;
  logic signed [35:0] py_t;
  logic signed [52:0] px_prod, pz_prod;
  logic signed [53:0] px_t, pz_t;
  logic signed [33:0] sqx, sqy, sqz;

  always_comb begin
    py_prod = $signed({1'b0, ry_r}) * cp_r;
    py_t    = {py_prod[34], py_prod} + 36'sd32768;
    px_prod = ax_r * ct1_r;
    pz_prod = az_r * stt1_r;
    px_t    = {px_prod[52], px_prod} + (54'sd1 <<< 31);
    pz_t    = {pz_prod[52], pz_prod} + (54'sd1 <<< 31);
    sqx     = p2_r.x * p2_r.x;
    sqy     = p2_r.y * p2_r.y;
    sqz     = p2_r.z * p2_r.z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_v_r <= 1'b0;
      m1_v_r  <= 1'b0;
      m2_v_r  <= 1'b0;
      sq_v_r  <= 1'b0;
      sum_v_r <= 1'b0;
    end else if (en) begin
      rnd_v_r <= cor_v[CORDIC_STAGES];
      m1_v_r  <= rnd_v_r;
      m2_v_r  <= m1_v_r;
      sq_v_r  <= m2_v_r;
      sum_v_r <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sp_r   <= rnd_q16(cor_d[CORDIC_STAGES].phi.y, cor_d[CORDIC_STAGES].phi.neg);
      cp_r   <= rnd_q16(cor_d[CORDIC_STAGES].phi.x, cor_d[CORDIC_STAGES].phi.neg);
      stt_r  <= rnd_q16(cor_d[CORDIC_STAGES].theta.y, cor_d[CORDIC_STAGES].theta.neg);
      ct_r   <= rnd_q16(cor_d[CORDIC_STAGES].theta.x, cor_d[CORDIC_STAGES].theta.neg);
      ax_r   <= $signed({1'b0, rx_r}) * sp_r;
      az_r   <= $signed({1'b0, rz_r}) * sp_r;
      py1_r  <= clamp17(22'($signed(py_t[35:16])));
      ct1_r  <= ct_r;
      stt1_r <= stt_r;
      p2_r.x <= clamp17(px_t[53:32]);
      p2_r.y <= py1_r;
      p2_r.z <= clamp17(pz_t[53:32]);
      sq_r[0] <= sqx;
      sq_r[1] <= sqy;
      sq_r[2] <= sqz;
      p3_r   <= p2_r;
      s_r    <= sq_r[0] + sq_r[1] + sq_r[2];
      p4_r   <= p3_r;
    end
  end

  // square root chain
  isq_t isq_d [ISQ_STAGES+1];
  logic isq_v [ISQ_STAGES+1];
  pos_t isq_p [ISQ_STAGES+1];

  assign isq_d[0].v = {2'b00, s_r, 28'd0};
  assign isq_d[0].r = '0;
  assign isq_v[0]   = sum_v_r;
  assign isq_p[0]   = p4_r;

  for (genvar i = 0; i < ISQ_STAGES; i++) begin : g_isq
    smvg_isqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .b(6'(62 - 2 * i)),
      .in_valid(isq_v[i]), .in_d(isq_d[i]),
      .out_valid(isq_v[i+1]), .out_d(isq_d[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        isq_p[i+1] <= isq_p[i];
      end
    end
  end

  // normal division chain
  ndiv_t nd_d [NDIV_STAGES+1];
  logic  nd_v [NDIV_STAGES+1];
  pos_t  nd_p [NDIV_STAGES+1];
  logic [30:0] len;

  assign len = isq_d[ISQ_STAGES].r[30:0];

  always_comb begin
    logic [2:0][16:0] pv;
    logic [15:0]      m;
    logic [44:0]      dd;
    pv = {isq_p[ISQ_STAGES].z, isq_p[ISQ_STAGES].y, isq_p[ISQ_STAGES].x};
    nd_d[0].len = len;
    for (int i = 0; i < 3; i++) begin
      m  = pv[i][16] ? 16'(-$signed(pv[i])) : pv[i][15:0];
      dd = {1'b0, m, 28'd0} + 45'(len >> 1);
      nd_d[0].rem[i] = {1'b0, dd[44:15]};
      nd_d[0].dq[i]  = dd[14:0];
    end
  end
  assign nd_v[0] = isq_v[ISQ_STAGES];
  assign nd_p[0] = isq_p[ISQ_STAGES];

  for (genvar i = 0; i < NDIV_STAGES; i++) begin : g_nd
    smvg_ndiv_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(nd_v[i]), .in_d(nd_d[i]),
      .out_valid(nd_v[i+1]), .out_d(nd_d[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        nd_p[i+1] <= nd_p[i];
      end
    end
  end

  assign last_v = nd_v[NDIV_STAGES];

  // final normal: clamp, restore sign, zero for a zero vector
  logic [2:0][15:0] nrm;
  always_comb begin
    logic [2:0][16:0] pv;
    logic [14:0]      q;
    logic [15:0]      qc;
    pv = {nd_p[NDIV_STAGES].z, nd_p[NDIV_STAGES].y, nd_p[NDIV_STAGES].x};
    for (int i = 0; i < 3; i++) begin
      q  = nd_d[NDIV_STAGES].dq[i];
      qc = (q > 15'd16384) ? 16'd16384 : {1'b0, q};
      if (nd_d[NDIV_STAGES].len == '0) begin
        nrm[i] = '0;
      end else begin
        nrm[i] = pv[i][16] ? 16'(-qc) : qc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && last_v) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && last_v) begin
      out_data_r <= {nrm[2], nrm[1], nrm[0],
                     nd_p[NDIV_STAGES].z, nd_p[NDIV_STAGES].y, nd_p[NDIV_STAGES].x};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_data_r};

`include "spheroid_mesh_vertex_generator_macros.svh"

  `SMVG_ASSERT_IMP(a_stall_only_when_blocked, !in_tready, out_valid_r && !out_tready && last_v, "input stalled without a blocked result")
  `SMVG_ASSERT_NXT(a_last_lands_in_output, en && last_v, out_valid_r, "result from last cell not registered")
  `SMVG_ASSERT_IMP(a_zero_pos_zero_norm, out_valid_r && out_data_r[50:0] == 51'd0, out_data_r[98:51] == 48'd0, "zero position with nonzero normal")
  `SMVG_ASSERT_IMP(a_norm_x_bound, out_valid_r, $signed(out_data_r[66:51]) <= 16'sd16384 && $signed(out_data_r[66:51]) >= -16'sd16384, "normal x out of range")

endmodule

@@ verif/tb_spheroid_mesh_vertex_generator.sv @@
// Self-checking testbench of the spheroid mesh vertex generator: grid vertices in, positions and normals out.
module tb_spheroid_mesh_vertex_generator;
  import smvg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [10:0] stack_idx;
    logic [10:0] slice_idx;
  } grid_pt_t;

  typedef struct packed {
    logic signed [16:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
  } vertex_t;

  typedef struct packed {
    logic        is_cfg;
    logic        pause;
    cfg_reg_t    reg_idx;
    logic [15:0] reg_val;
    grid_pt_t    pt;
  } job_t;

  localparam logic [31:0] ATAN_TBL [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };
  localparam int PIPE_DEPTH = 101;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [23:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;

  logic [15:0] rad_x = 16'd256, rad_y = 16'd256, rad_z = 16'd256;
  logic [10:0] n_slices = 11'd16, n_stacks = 11'd16;

  job_t    job_q[$];
  vertex_t vertex_q[$];
  int      n_errors = 0;
  int      drv_gap = 0;
  int      idle_wait = 0;
  int      sink_gap = 0;
  bit      stim_done = 0;

  spheroid_mesh_vertex_generator DUT (.*);

  always #1 clk = ~clk;

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic longint active_count(logic [10:0] c);
    if (c == 0) return 1;
    if (c > MAX_DIVISIONS) return MAX_DIVISIONS;
    return c;
  endfunction

  // rotation CORDIC on a 2^-32 turn angle, results rounded to Q.16
  task automatic sin_cos(input longint ang, output longint s, output longint c);
    longint a, x, y, z, dx, dy;
    bit     flip;
    a = ang & 64'hFFFFFFFF;
    flip = ((a + 64'h40000000) & 64'hFFFFFFFF) >= 64'h80000000;
    if (flip) a = (a - 64'h80000000) & 64'hFFFFFFFF;
    z = a < 64'h80000000 ? a : a - 64'h100000000;
    x = 652032874;
    y = 0;
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      dx = floor_shr(y, k);
      dy = floor_shr(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TBL[k]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TBL[k]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(floor_shr(x + 8192, 14), 65536);
    s = clip(floor_shr(y + 8192, 14), 65536);
  endtask

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unit_comp(longint p, longint unsigned len);
    longint unsigned m, q;
    m = p < 0 ? -p : p;
    q = ((m << 28) + len / 2) / len;
    if (q > 16384) q = 16384;
    return p < 0 ? -longint'(q) : longint'(q);
  endfunction

  task automatic predict_vertex(input grid_pt_t pt, output vertex_t v);
    longint stacks, slices, st, sl, sp, cp, stt, ct;
    longint p[3];
    longint unsigned sum, len;
    stacks = active_count(n_stacks);
    slices = active_count(n_slices);
    st = pt.stack_idx > stacks ? stacks : pt.stack_idx;
    sl = pt.slice_idx > slices ? slices : pt.slice_idx;
    sin_cos((st << 31) / stacks, sp, cp);
    sin_cos((sl << 32) / slices, stt, ct);
    p[0] = clip(floor_shr(longint'(rad_x) * sp * ct + (64'sd1 <<< 31), 32), 65535);
    p[1] = clip(floor_shr(longint'(rad_y) * cp + (64'sd1 <<< 15), 16), 65535);
    p[2] = clip(floor_shr(longint'(rad_z) * sp * stt + (64'sd1 <<< 31), 32), 65535);
    sum = p[0] * p[0] + p[1] * p[1] + p[2] * p[2];
    len = sum != 0 ? int_sqrt(sum << 28) : 0;
    v.px = 17'(p[0]); v.py = 17'(p[1]); v.pz = 17'(p[2]);
    v.nx = 16'(len != 0 ? unit_comp(p[0], len) : 0);
    v.ny = 16'(len != 0 ? unit_comp(p[1], len) : 0);
    v.nz = 16'(len != 0 ? unit_comp(p[2], len) : 0);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic job_t grid_job(int st, int sl);
    job_t j = '0;
    j.pt.stack_idx = 11'(st);
    j.pt.slice_idx = 11'(sl);
    return j;
  endfunction

  function automatic job_t cfg_job(cfg_reg_t r, logic [15:0] val);
    job_t j = '0;
    j.is_cfg = 1'b1;
    j.reg_idx = r;
    j.reg_val = val;
    return j;
  endfunction

  function automatic job_t pause_job();
    job_t j = '0;
    j.pause = 1'b1;
    return j;
  endfunction

  function automatic void add_job(job_t j);
    job_q.insert(job_q.size(), j);
  endfunction

  // driver: config writes and pauses wait for the pipeline to drain
  always @(posedge clk) begin
    if (rst_n && !((in_tvalid && !in_tready) || (cfg_valid && !cfg_ready))) begin
      if (drv_gap > 0) begin
        in_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        drv_gap <= drv_gap - 1;
      end else if (job_q.size() > 0) begin
        if (job_q[0].is_cfg || job_q[0].pause) begin
          in_tvalid <= 1'b0;
          if (vertex_q.size() != 0 || in_tvalid) begin
            cfg_valid <= 1'b0;
            idle_wait <= 0;
          end else if (idle_wait < PIPE_DEPTH + 4) begin
            cfg_valid <= 1'b0;
            idle_wait <= idle_wait + 1;
          end else begin
            idle_wait <= 0;
            cfg_valid <= job_q[0].is_cfg;
            if (job_q[0].is_cfg) begin
              cfg_index <= job_q[0].reg_idx;
              cfg_data  <= job_q[0].reg_val;
              case (job_q[0].reg_idx)
                REG_RADIUS_X:    rad_x <= job_q[0].reg_val;
                REG_RADIUS_Y:    rad_y <= job_q[0].reg_val;
                REG_RADIUS_Z:    rad_z <= job_q[0].reg_val;
                REG_SLICE_COUNT: n_slices <= job_q[0].reg_val[10:0];
                REG_STACK_COUNT: n_stacks <= job_q[0].reg_val[10:0];
                default: ;
              endcase
            end
            void'(job_q.pop_front());
          end
        end else begin
          vertex_t v;
          predict_vertex(job_q[0].pt, v);
          vertex_q.insert(vertex_q.size(), v);
          cfg_valid <= 1'b0;
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b0, job_q[0].pt.slice_idx, job_q[0].pt.stack_idx};
          void'(job_q.pop_front());
          drv_gap <= pick_gap();
        end
      end else begin
        in_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // monitor and sink stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        vertex_t got, want;
        got = {out_tdata[16:0], out_tdata[33:17], out_tdata[50:34],
               out_tdata[66:51], out_tdata[82:67], out_tdata[98:83]};
        if (vertex_q.size() == 0) begin
          report_mismatch("unexpected vertex", 1, 0);
        end else begin
          want = vertex_q.pop_front();
          if (got.px !== want.px) report_mismatch("pos_x", got.px, want.px);
          if (got.py !== want.py) report_mismatch("pos_y", got.py, want.py);
          if (got.pz !== want.pz) report_mismatch("pos_z", got.pz, want.pz);
          if (got.nx !== want.nx) report_mismatch("norm_x", got.nx, want.nx);
          if (got.ny !== want.ny) report_mismatch("norm_y", got.ny, want.ny);
          if (got.nz !== want.nz) report_mismatch("norm_z", got.nz, want.nz);
        end
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        sink_gap <= pick_gap();
      end
    end
  end

  initial begin
    int dims[5];
    int ns, nt;
    logic [15:0] rv[3];
    // directed: reset setting, poles, seams, saturation
    add_job(grid_job(0, 0));
    add_job(grid_job(16, 0));
    add_job(grid_job(8, 0));
    add_job(grid_job(8, 4));
    add_job(grid_job(8, 8));
    add_job(grid_job(8, 12));
    add_job(grid_job(8, 16));
    add_job(grid_job(2047, 2047));
    add_job(grid_job(4, 1024));
    add_job(grid_job(12, 3));
    // zero radii give a zero vector, then maximum radii
    add_job(cfg_job(REG_RADIUS_X, 16'd0));
    add_job(cfg_job(REG_RADIUS_Y, 16'd0));
    add_job(cfg_job(REG_RADIUS_Z, 16'd0));
    add_job(grid_job(5, 3));
    add_job(cfg_job(REG_RADIUS_X, 16'hFFFF));
    add_job(cfg_job(REG_RADIUS_Y, 16'hFFFF));
    add_job(cfg_job(REG_RADIUS_Z, 16'hFFFF));
    add_job(grid_job(0, 0));
    add_job(grid_job(8, 2));
    add_job(grid_job(6, 1));
    // count of zero and above the maximum
    add_job(cfg_job(REG_SLICE_COUNT, 16'd0));
    add_job(cfg_job(REG_STACK_COUNT, 16'h07FF));
    add_job(grid_job(512, 0));
    add_job(grid_job(1024, 1));
    add_job(grid_job(300, 5));
    add_job(pause_job());
    dims = '{1, 2, 3, 1024, 0};
    for (int ph = 0; ph < 12; ph++) begin
      ns = ph < 5 ? dims[ph] : $urandom_range(1, 1024);
      nt = ph < 5 ? dims[4 - ph] : $urandom_range(1, 1024);
      if (ph == 6) ns = 2047;
      for (int r = 0; r < 3; r++) begin
        case ($urandom_range(0, 3))
          0: rv[r] = 16'd0;
          1: rv[r] = 16'hFFFF;
          default: rv[r] = 16'($urandom);
        endcase
      end
      add_job(cfg_job(REG_RADIUS_X, rv[0]));
      add_job(cfg_job(REG_RADIUS_Y, rv[1]));
      add_job(cfg_job(REG_RADIUS_Z, rv[2]));
      add_job(cfg_job(REG_SLICE_COUNT, 16'(ns)));
      add_job(cfg_job(REG_STACK_COUNT, 16'(nt)));
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 9) == 0)
          add_job(grid_job($urandom_range(0, 2047), $urandom_range(0, 2047)));
        else
          add_job(grid_job($urandom_range(0, nt > 0 ? nt : 1),
                           $urandom_range(0, ns > 0 ? ns : 1)));
      end
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && job_q.size() == 0 && vertex_q.size() == 0);
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/smvg_pkg.sv
sv/smvg_adiv_cell.sv
sv/smvg_cordic_cell.sv
sv/smvg_isqrt_cell.sv
sv/smvg_ndiv_cell.sv
sv/spheroid_mesh_vertex_generator.sv
verif/tb_spheroid_mesh_vertex_generator.sv
